[rtl/core/knapsack_dp_traceback_unit_assert.svh]
// ----------------------------------------------------------------------------
// Knapsack traceback unit assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef KNAPSACK_DP_TRACEBACK_UNIT_ASSERT_SVH
`define KNAPSACK_DP_TRACEBACK_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("knapsack traceback unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knapsack traceback unit: next-cycle check failed");

`endif

[rtl/core/kdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack traceback package
// Field widths, defaults and result codes shared by the unit and its channels.
// ----------------------------------------------------------------------------
package kdt_pkg;

  localparam int DEF_MAX_ITEMS    = 16;
  localparam int DEF_MAX_CAPACITY = 255;

  localparam int W_WEIGHT = 8;
  localparam int W_PROFIT = 12;
  localparam int W_CAP    = 8;
  localparam int W_INDEX  = 5;
  localparam int W_AMOUNT = 16;

  localparam logic [W_CAP-1:0]    CAP_RESET  = 8'd255;
  localparam logic [W_AMOUNT-1:0] AMOUNT_MAX = 16'hFFFF;

  // Result kinds.
  localparam logic KIND_ITEM  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

endpackage

[rtl/core/kdt_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack capacity write channel
// Valid/ready channel carrying the capacity register's write data.
// ----------------------------------------------------------------------------
interface kdt_cfg_if
  import kdt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [W_CAP-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/kdt_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack item channel
// Valid/ready channel carrying one item's weight, profit and end-of-set flag.
// ----------------------------------------------------------------------------
interface kdt_item_if
  import kdt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [W_WEIGHT-1:0] weight;
  logic [W_PROFIT-1:0] profit;
  logic                last_item;

  modport source (output valid, output weight, output profit, output last_item, input ready);
  modport sink   (input valid, input weight, input profit, input last_item, output ready);
endinterface

[rtl/core/kdt_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack result channel
// Valid/ready channel carrying selected items and the optimal total.
// ----------------------------------------------------------------------------
interface kdt_result_if
  import kdt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [W_INDEX-1:0]  item_index;
  logic [W_AMOUNT-1:0] amount;
  logic                last_result;

  modport source (output valid, output result_kind, output item_index, output amount,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input item_index, input amount,
                  input last_result, output ready);
endinterface

[rtl/core/knapsack_dp_traceback_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack traceback unit
// 0/1 knapsack solver: fills the best-value table one row per item from a
// dual-read synchronous memory, then traces back and reports the chosen items and the total.
// ----------------------------------------------------------------------------
// Items: a new item is taken only in idle, once the previous item's row fill
//   is done; the fill writes one table column per cycle through one port.
// After the last item: any row fill, then traceback steps that each read and
//   compare, then a scan of the stored items reporting each chosen one, then the total.
// Reset: control state clears and capacity returns to 255; the table and item
//   stores are left undefined, as every entry is written before it is read.
`include "knapsack_dp_traceback_unit_assert.svh"

module knapsack_dp_traceback_unit
  import kdt_pkg::*;
#(
  parameter int MAX_ITEMS    = DEF_MAX_ITEMS,
  parameter int MAX_CAPACITY = DEF_MAX_CAPACITY
) (
  input  logic  clk,
  input  logic  rst,
  kdt_cfg_if.sink      cfg,
  kdt_item_if.sink     items,
  kdt_result_if.source results
);

  localparam int NCOLS     = MAX_CAPACITY + 1;
  localparam int TBL_DEPTH = MAX_ITEMS * NCOLS;
  localparam int ROW_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int COL_W     = $clog2(NCOLS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CMP_W     = (COL_W > W_WEIGHT) ? COL_W : W_WEIGHT;

  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(MAX_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FILL    = 8'b0000_0010,
    S_DRAIN   = 8'b0000_0100,
    S_TB_RD   = 8'b0000_1000,
    S_TB_CMP  = 8'b0001_0000,
    S_EM_SCAN = 8'b0010_0000,
    S_EM_WAIT = 8'b0100_0000,
    S_TOTAL   = 8'b1000_0000
  } state_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    tbl_addr = ADDR_W'(int'(row) * NCOLS + int'(col));
  endfunction

  state_t state, state_next;

  // Control and item registers.
  logic [W_CAP-1:0]    capacity;
  logic [CNT_W-1:0]    count;
  logic [W_WEIGHT-1:0] wt_q;
  logic [W_PROFIT-1:0] pr_q;
  logic                last_q;
  logic [ROW_W-1:0]    f_row;
  logic                f_first;
  logic [COL_W-1:0]    col;
  logic                s1_valid;
  logic [COL_W-1:0]    s1_col;
  logic                s1_fits;
  logic [CNT_W-1:0]    ti;
  logic [COL_W-1:0]    tj;
  logic [MAX_ITEMS-1:0] taken;
  logic [CNT_W-1:0]    ek;
  logic [W_AMOUNT-1:0] total;

  logic                res_valid;
  logic                res_kind;
  logic [W_INDEX-1:0]  res_index;
  logic [W_AMOUNT-1:0] res_amount;
  logic                res_last;

  // Memories.
  logic [W_AMOUNT-1:0] table_mem [TBL_DEPTH];
  logic [W_WEIGHT-1:0] weight_mem [MAX_ITEMS];
  logic [W_PROFIT-1:0] profit_mem [MAX_ITEMS];
  logic [W_AMOUNT-1:0] rd_a, rd_b;
  logic [W_WEIGHT-1:0] w_rd;
  logic [W_PROFIT-1:0] p_rd;

  logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b, wr_addr;
  logic [W_AMOUNT-1:0] wr_data;
  logic                item_xfer, out_free, fits, res_load;
  logic [COL_W-1:0]    col_minus_wt;
  logic [COL_W-1:0]    cap_sat;
  logic [W_AMOUNT-1:0] up_val, diag_val, cand, tb_b_val;
  logic [W_AMOUNT:0]   cand_sum, total_sum;

  assign cfg.ready     = 1'b1;
  assign items.ready   = (state == S_IDLE);
  assign item_xfer     = items.valid && items.ready;
  assign out_free      = !res_valid || results.ready;
  assign res_load      = ((state == S_EM_WAIT) || (state == S_TOTAL)) && out_free;

  assign results.valid       = res_valid;
  assign results.result_kind = res_kind;
  assign results.item_index  = res_index;
  assign results.amount      = res_amount;
  assign results.last_result = res_last;

  assign fits         = (col != '0) && (CMP_W'(wt_q) <= CMP_W'(col));
  assign col_minus_wt = COL_W'(CMP_W'(col) - CMP_W'(wt_q));
  assign cap_sat      = (CMP_W'(capacity) > CMP_W'(COL_LAST)) ? COL_LAST : COL_W'(capacity);

  // Read addresses: the fill reads the row above, the traceback reads table rows ti-1 and ti-2.
  always_comb begin
    if (state == S_FILL) begin
      rd_addr_a = tbl_addr(f_row - ROW_W'(1), col);
      rd_addr_b = tbl_addr(f_row - ROW_W'(1), col_minus_wt);
    end else begin
      rd_addr_a = tbl_addr(ROW_W'(ti - CNT_ONE), tj);
      rd_addr_b = tbl_addr(ROW_W'(ti - CNT_W'(2)), tj);
    end
  end

  // Write side of the fill. The row written is never the row being read, so
  // no forwarding is needed; the first row sees zeros above it.
  always_comb begin
    up_val   = f_first ? '0 : rd_a;
    diag_val = f_first ? '0 : rd_b;
    cand_sum = {1'b0, diag_val} + (W_AMOUNT + 1)'(pr_q);
    cand     = cand_sum[W_AMOUNT] ? AMOUNT_MAX : cand_sum[W_AMOUNT-1:0];
    if (s1_col == '0) begin
      wr_data = '0;
    end else if (s1_fits && (cand > up_val)) begin
      wr_data = cand;
    end else begin
      wr_data = up_val;
    end
    wr_addr  = tbl_addr(f_row, s1_col);
    tb_b_val = (ti == CNT_ONE) ? '0 : rd_b;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_a <= table_mem[rd_addr_a];
    rd_b <= table_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (item_xfer && (count < CNT_LIMIT)) begin
      weight_mem[ROW_W'(count)] <= items.weight;
      profit_mem[ROW_W'(count)] <= items.profit;
    end
    w_rd <= weight_mem[ROW_W'(ti - CNT_ONE)];
    p_rd <= profit_mem[ROW_W'(ek - CNT_ONE)];
  end

  assign total_sum = {1'b0, total} + (W_AMOUNT + 1)'(p_rd);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_xfer) begin
          if (count < CNT_LIMIT) begin
            state_next = S_FILL;
          end else if (items.last_item) begin
            state_next = S_TB_RD;
          end
        end
      end
      S_FILL: begin
        if (col == COL_LAST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:   state_next = last_q ? S_TB_RD : S_IDLE;
      S_TB_RD:   state_next = ((ti == '0) || (tj == '0)) ? S_EM_SCAN : S_TB_CMP;
      S_TB_CMP:  state_next = S_TB_RD;
      S_EM_SCAN: begin
        if (ek > count) begin
          state_next = S_TOTAL;
        end else if (taken[ROW_W'(ek - CNT_ONE)]) begin
          state_next = S_EM_WAIT;
        end
      end
      S_EM_WAIT: begin
        if (out_free) begin
          state_next = S_EM_SCAN;
        end
      end
      S_TOTAL: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      count     <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == S_FILL);
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (item_xfer) begin
        wt_q   <= items.weight;
        pr_q   <= items.profit;
        last_q <= items.last_item;
        col    <= '0;
        if (count < CNT_LIMIT) begin
          f_row   <= ROW_W'(count);
          f_first <= (count == '0);
          count   <= count + CNT_ONE;
        end else begin
          ti    <= count;
          tj    <= cap_sat;
          taken <= '0;
        end
      end
      if (state == S_FILL) begin
        s1_col  <= col;
        s1_fits <= fits;
        col     <= col + COL_W'(1);
      end
      if (state == S_DRAIN) begin
        ti    <= count;
        tj    <= cap_sat;
        taken <= '0;
      end
      if (state == S_TB_RD) begin
        ek    <= CNT_ONE;
        total <= '0;
      end
      if (state == S_TB_CMP) begin
        // An item was taken where its row differs from the row above.
        if (rd_a != tb_b_val) begin
          taken[ROW_W'(ti - CNT_ONE)] <= 1'b1;
          tj <= (CMP_W'(w_rd) <= CMP_W'(tj)) ? COL_W'(CMP_W'(tj) - CMP_W'(w_rd)) : '0;
        end
        ti <= ti - CNT_ONE;
      end
      if ((state == S_EM_SCAN) && (ek <= count) && !taken[ROW_W'(ek - CNT_ONE)]) begin
        ek <= ek + CNT_ONE;
      end
      if ((state == S_EM_WAIT) && out_free) begin
        res_kind   <= KIND_ITEM;
        res_index  <= W_INDEX'(ek);
        res_amount <= W_AMOUNT'(p_rd);
        res_last   <= 1'b0;
        total      <= total_sum[W_AMOUNT] ? AMOUNT_MAX : total_sum[W_AMOUNT-1:0];
        ek         <= ek + CNT_ONE;
      end
      if ((state == S_TOTAL) && out_free) begin
        res_kind   <= KIND_TOTAL;
        res_index  <= '0;
        res_amount <= total;
        res_last   <= 1'b1;
        count      <= '0;
      end
    end
  end

  `KDT_ASSERT_NOW(a_last_is_total, res_valid && res_last, res_kind == KIND_TOTAL && res_index == '0)
  `KDT_ASSERT_NEXT(a_one_item_at_a_time, item_xfer && (count < CNT_LIMIT), !items.ready)
  `KDT_ASSERT_NEXT(a_column_never_grows, state == S_TB_CMP, tj <= $past(tj))

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knapsack traceback unit testbench
// Sends item sets through the item channel under several capacities, solves
// each set in parallel with the unit, and checks every reported item and
// total in order. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
  import kdt_pkg::*;
();

  localparam int NUM_COLS     = DEF_MAX_CAPACITY + 1;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic [W_WEIGHT-1:0] weight;
    logic [W_PROFIT-1:0] profit;
    logic                last_item;
  } knap_item_t;

  typedef struct packed {
    logic                kind;
    logic [W_INDEX-1:0]  index;
    logic [W_AMOUNT-1:0] amount;
    logic                last;
  } pick_t;

  logic clk;
  logic rst;

  kdt_cfg_if    cfg_ch();
  kdt_item_if   item_ch();
  kdt_result_if res_ch();

  knapsack_dp_traceback_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .items   (item_ch),
    .results (res_ch)
  );

  always #6 clk = ~clk;

  // Solver state, kept alongside the unit.
  logic [W_WEIGHT-1:0] kept_weight [DEF_MAX_ITEMS];
  logic [W_PROFIT-1:0] kept_profit [DEF_MAX_ITEMS];
  logic [W_AMOUNT-1:0] best_value  [DEF_MAX_ITEMS][NUM_COLS];
  int unsigned         stored_count;
  logic [W_CAP-1:0]    cap_now;

  knap_item_t items_to_send[$];
  pick_t      picks_due[$];

  knap_item_t cur_item;
  pick_t      got_pick;
  pick_t      want_pick;
  bit         sending;
  bit         item_landed;
  bit         result_landed;
  int         item_gap;
  int         item_quiet;
  int         result_stall;
  int         result_quiet;

  int items_taken;
  int sets_solved;
  int picks_checked;
  int caps_used;
  int mismatches;

  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    // Now and then a run of transfers with no idling at all.
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [W_AMOUNT-1:0] grid_at(int unsigned row, int unsigned col);
    if (row == 0 || row > DEF_MAX_ITEMS || col > DEF_MAX_CAPACITY)
      return '0;
    return best_value[row-1][col];
  endfunction

  // Adds one item to the current set and, on the final item, solves the set
  // and queues the chosen items followed by the total.
  task automatic absorb_item(input logic [W_WEIGHT-1:0] w, input logic [W_PROFIT-1:0] p,
                             input logic last_item);
    int unsigned row;
    int unsigned col;
    int unsigned cand;
    int unsigned val;
    int unsigned total;
    bit          taken [DEF_MAX_ITEMS+1];
    pick_t       pk;

    items_taken++;
    if (stored_count < DEF_MAX_ITEMS) begin
      kept_weight[stored_count] = w;
      kept_profit[stored_count] = p;
      stored_count++;
      row = stored_count;
      for (col = 0; col <= DEF_MAX_CAPACITY; col++) begin
        val = grid_at(row - 1, col);
        if (col != 0 && w <= col) begin
          cand = grid_at(row - 1, col - w) + p;
          if (cand > AMOUNT_MAX)
            cand = AMOUNT_MAX;
          if (cand > val)
            val = cand;
        end
        if (col == 0)
          val = 0;
        best_value[row-1][col] = val[W_AMOUNT-1:0];
      end
    end
    if (!last_item)
      return;

    foreach (taken[k])
      taken[k] = 1'b0;
    row = stored_count;
    col = (cap_now > DEF_MAX_CAPACITY) ? DEF_MAX_CAPACITY : cap_now;
    while (row != 0 && col != 0) begin
      if (grid_at(row, col) != grid_at(row - 1, col)) begin
        taken[row] = 1'b1;
        col = (kept_weight[row-1] <= col) ? col - kept_weight[row-1] : 0;
      end
      row--;
    end

    total = 0;
    for (row = 1; row <= stored_count; row++) begin
      if (taken[row]) begin
        pk.kind   = KIND_ITEM;
        pk.index  = row[W_INDEX-1:0];
        pk.amount = W_AMOUNT'(kept_profit[row-1]);
        pk.last   = 1'b0;
        picks_due.push_back(pk);
        total += kept_profit[row-1];
        if (total > AMOUNT_MAX)
          total = AMOUNT_MAX;
      end
    end
    pk.kind   = KIND_TOTAL;
    pk.index  = '0;
    pk.amount = total[W_AMOUNT-1:0];
    pk.last   = 1'b1;
    picks_due.push_back(pk);
    stored_count = 0;
    sets_solved++;
  endtask

  // Item driver: offers the next item after its drawn gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_landed) begin
        item_landed = 1'b0;
        sending     = 1'b0;
        item_gap    = draw_wait(item_quiet);
      end
      if (!sending) begin
        if (item_gap > 0) begin
          item_gap--;
        end else if (items_to_send.size() != 0) begin
          cur_item = items_to_send.pop_front();
          sending  = 1'b1;
          item_ch.weight    <= cur_item.weight;
          item_ch.profit    <= cur_item.profit;
          item_ch.last_item <= cur_item.last_item;
        end
      end
      item_ch.valid <= sending;
    end
  end

  // Result sink: holds ready low for a drawn stall after each transfer.
  always @(negedge clk) begin
    if (!rst) begin
      if (result_landed) begin
        result_landed = 1'b0;
        result_stall  = draw_wait(result_quiet);
      end
      if (result_stall > 0) begin
        result_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: both channels are sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        absorb_item(item_ch.weight, item_ch.profit, item_ch.last_item);
        item_landed = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        result_landed   = 1'b1;
        got_pick.kind   = res_ch.result_kind;
        got_pick.index  = res_ch.item_index;
        got_pick.amount = res_ch.amount;
        got_pick.last   = res_ch.last_result;
        if (picks_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing outstanding: kind %0d index %0d amount %0d last %0d",
                   $time, got_pick.kind, got_pick.index, got_pick.amount, got_pick.last);
        end else begin
          want_pick = picks_due.pop_front();
          picks_checked++;
          if (got_pick.kind !== want_pick.kind || got_pick.index !== want_pick.index ||
              got_pick.amount !== want_pick.amount || got_pick.last !== want_pick.last) begin
            mismatches++;
            $display("%0t: expected kind %0d index %0d amount %0d last %0d", $time,
                     want_pick.kind, want_pick.index, want_pick.amount, want_pick.last);
            $display("%0t:   actual kind %0d index %0d amount %0d last %0d", $time,
                     got_pick.kind, got_pick.index, got_pick.amount, got_pick.last);
          end
        end
      end
    end
  end

  task automatic queue_item(input int w, input int p, input bit last_item);
    knap_item_t it;
    it.weight    = W_WEIGHT'(w);
    it.profit    = W_PROFIT'(p);
    it.last_item = last_item;
    items_to_send.push_back(it);
  endtask

  task automatic write_capacity(input logic [W_CAP-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    cap_now = value;
    caps_used++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every item has gone in and every result has come out, then
  // allows for a row fill still in progress.
  task automatic wait_idle();
    while (items_to_send.size() != 0 || sending || picks_due.size() != 0)
      @(posedge clk);
    repeat (DEF_MAX_CAPACITY + 16) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          phase_items;
    int          set_len;
    int          span;
    int          k;
    logic [W_CAP-1:0] next_cap;

    clk               = 1'b0;
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    item_ch.valid     = 1'b0;
    item_ch.weight    = '0;
    item_ch.profit    = '0;
    item_ch.last_item = 1'b0;
    res_ch.ready      = 1'b0;
    cap_now           = CAP_RESET;
    stored_count      = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Capacity left at its reset value: weightless item, worthless item,
    // heaviest item, then a set that overruns the item store.
    queue_item(0, 4095, 1'b1);
    queue_item(255, 0, 1'b1);
    queue_item(255, 4095, 1'b1);
    for (k = 1; k <= DEF_MAX_ITEMS; k++)
      queue_item(k, (k % 2 == 0) ? 'hAAA : 'h555, 1'b0);
    queue_item(1, 4095, 1'b1);
    wait_idle();

    // Zero capacity takes nothing, even an item of no weight.
    write_capacity(8'd0);
    queue_item(0, 100, 1'b0);
    queue_item(3, 7, 1'b1);
    wait_idle();

    write_capacity(8'd1);
    queue_item(1, 5, 1'b0);
    queue_item(1, 9, 1'b1);
    wait_idle();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: next_cap = 8'hFF;
        1: next_cap = 8'h00;
        2: next_cap = W_CAP'($urandom_range(1, 31));
        3: next_cap = W_CAP'($urandom_range(32, 254));
        default: next_cap = W_CAP'($urandom_range(0, 255));
      endcase
      write_capacity(next_cap);
      // Weights mostly well under the capacity so that several items fit.
      span = next_cap / 3 + 2;
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(0, 9) == 0)
          set_len = $urandom_range(DEF_MAX_ITEMS + 1, DEF_MAX_ITEMS + 4);
        else
          set_len = $urandom_range(1, DEF_MAX_ITEMS);
        for (k = 0; k < set_len; k++)
          queue_item(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, span),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 4095),
                     k == set_len - 1);
        phase_items += set_len;
      end
      wait_idle();
    end

    $display("Run covered %0d items in %0d sets under %0d capacity writes.",
             items_taken, sets_solved, caps_used);
    $display("%0d results checked, %0d mismatches.", picks_checked, mismatches);
    if (mismatches == 0)
      $display("knapsack_dp_traceback_unit: match");
    else
      $display("knapsack_dp_traceback_unit: mismatch");
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d results outstanding.", picks_due.size());
    $display("knapsack_dp_traceback_unit: mismatch");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/kdt_pkg.sv
rtl/core/kdt_cfg_if.sv
rtl/core/kdt_item_if.sv
rtl/core/kdt_result_if.sv
rtl/core/knapsack_dp_traceback_unit.sv
tb/testbench.sv
